@@ src/cv3s2_pkg.sv @@
package cv3s2_pkg;

  localparam int MaxInWidth    = 256;
  localparam int MaxOutPixels  = 4096;
  localparam int MaxInChannels = 1024;
  localparam int RowLimit      = 256;
  localparam int KernelTaps    = 3 * 3;
  localparam int ShiftTaps     = 6;

  localparam int ColW  = $clog2(MaxInWidth);
  localparam int RowW  = $clog2(RowLimit);
  localparam int ChanW = $clog2(MaxInChannels);
  localparam int AccAw = $clog2(MaxOutPixels);
  localparam int AccW  = 48;
  localparam int ProdW = 32;
  localparam int SumW  = 36;

  typedef enum logic {
    FUNC_WEIGHT = 1'b0,
    FUNC_PIXEL  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    CFG_IN_WIDTH    = 3'd0,
    CFG_IN_HEIGHT   = 3'd1,
    CFG_OUT_WIDTH   = 3'd2,
    CFG_OUT_HEIGHT  = 3'd3,
    CFG_IN_CHANNELS = 3'd4
  } cfg_idx_e;

endpackage

@@ src/conv3x3_stride2_channel_accumulate.sv @@
// a last-channel window pixel goes through s1_, s2_ and s3_valid_q, then raises m_axis_tvalid
// throughput: 1 beat per cycle, weights and pixels alike; the pipeline stalls only
// while a result waits on m_axis_tready
// accumulators use one read and one write port; the first channel of a map reads them as zero
// reset: asynchronous active low, clears counters, weights, window and config to defaults
module conv3x3_stride2_channel_accumulate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // weight_index[3:0], sample[19:4], zero pad
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // result[47:0], out_x[53:48], out_y[59:54], zero pad
  output logic        m_axis_tlast
);
  import cv3s2_pkg::*;

  logic [8:0]  in_width_q, in_height_q;
  logic [6:0]  out_width_q, out_height_q;
  logic [10:0] in_channels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q    <= 9'd3;
      in_height_q   <= 9'd3;
      out_width_q   <= 7'd1;
      out_height_q  <= 7'd1;
      in_channels_q <= 11'd1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_IN_WIDTH:    in_width_q    <= cfg_wdata_i[8:0];
        CFG_IN_HEIGHT:   in_height_q   <= cfg_wdata_i[8:0];
        CFG_OUT_WIDTH:   out_width_q   <= cfg_wdata_i[6:0];
        CFG_OUT_HEIGHT:  out_height_q  <= cfg_wdata_i[6:0];
        CFG_IN_CHANNELS: in_channels_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [8:0]  ew, eh;
  logic [10:0] ec;
  always_comb begin
    ew = (in_width_q == '0) ? 9'd1 : (in_width_q > 9'(MaxInWidth) ? 9'(MaxInWidth) : in_width_q);
    eh = (in_height_q == '0) ? 9'd1 : (in_height_q > 9'(RowLimit) ? 9'(RowLimit) : in_height_q);
    ec = (in_channels_q == '0) ? 11'd1 :
         (in_channels_q > 11'(MaxInChannels) ? 11'(MaxInChannels) : in_channels_q);
  end

  logic en, accept, acc_pix;
  logic m_valid_q;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign acc_pix       = accept && (s_axis_tuser == FUNC_PIXEL);

  // stage 0: position counters and window decode
  logic [ColW-1:0]  col_q, c;
  logic [RowW-1:0]  row_q, r;
  logic [ChanW-1:0] chan_q, ch;
  logic [8:0]  c_nx, r_nx;
  logic [10:0] ch_nx;
  logic [6:0]  ox, oy;
  logic [12:0] idx13;
  logic        win;

  always_comb begin
    c = ({1'b0, col_q} >= ew) ? '0 : col_q;
    r = ({1'b0, row_q} >= eh) ? '0 : row_q;
    ch = ({1'b0, chan_q} >= ec) ? '0 : chan_q;
    c_nx = {1'b0, c} + 9'd1;
    r_nx = {1'b0, r} + 9'd1;
    ch_nx = {1'b0, ch} + 11'd1;
    ox = 7'((c - 8'd2) >> 1);
    oy = 7'((r - 8'd2) >> 1);
    idx13 = 13'(oy) * 13'(out_width_q) + 13'(ox);
    win = (r >= 8'd2) && (c >= 8'd2) && !r[0] && !c[0] &&
          (ox < out_width_q) && (oy < out_height_q) && (ox < 7'd64) && (oy < 7'd64) &&
          (idx13 < 13'(MaxOutPixels));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= '0;
    end else if (acc_pix) begin
      if (c_nx >= ew) begin
        col_q <= '0;
        if (r_nx >= eh) begin
          row_q  <= '0;
          chan_q <= (ch_nx >= ec) ? '0 : ch_nx[ChanW-1:0];
        end else begin
          row_q  <= r_nx[RowW-1:0];
          chan_q <= ch;
        end
      end else begin
        col_q  <= c_nx[ColW-1:0];
        row_q  <= r;
        chan_q <= ch;
      end
    end
  end

  // stage 1: line buffer data, window and products
  logic             s1_valid_q, s1_pix_q, s1_win_q, s1_emit_q, s1_first_q, s1_last_q;
  logic [3:0]       s1_widx_q;
  logic [15:0]      s1_sample_q;
  logic [AccAw-1:0] s1_idx_q;
  logic [5:0]       s1_ox_q, s1_oy_q;
  logic [ColW-1:0]  s1_addr_q;
  logic             s1_fwd_q;
  logic [31:0]      s1_fwd_data_q;

  logic [31:0] lb_mem [MaxInWidth];
  logic [31:0] lb_rdata_q, lbd, lb_wdata;
  logic [15:0] cur [3];
  logic [15:0] w_q [KernelTaps];
  logic [15:0] ws_q [ShiftTaps];
  logic [ProdW-1:0] prod [KernelTaps];

  always_comb begin
    lbd      = s1_fwd_q ? s1_fwd_data_q : lb_rdata_q;
    cur[0]   = lbd[15:0];
    cur[1]   = lbd[31:16];
    cur[2]   = s1_sample_q;
    lb_wdata = {s1_sample_q, cur[1]};
    for (int k = 0; k < 3; k++) begin
      prod[3*k]   = $signed(ws_q[2*k])   * $signed(w_q[3*k]);
      prod[3*k+1] = $signed(ws_q[2*k+1]) * $signed(w_q[3*k+1]);
      prod[3*k+2] = $signed(cur[k])      * $signed(w_q[3*k+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (acc_pix) lb_rdata_q <= lb_mem[c];
      if (s1_valid_q && s1_pix_q) lb_mem[s1_addr_q] <= lb_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pix_q      <= s_axis_tuser == FUNC_PIXEL;
      s1_widx_q     <= s_axis_tdata[3:0];
      s1_sample_q   <= s_axis_tdata[19:4];
      s1_win_q      <= win;
      s1_idx_q      <= idx13[AccAw-1:0];
      s1_emit_q     <= {1'b0, ch_nx} >= {1'b0, ec};
      s1_first_q    <= ch == '0;
      s1_ox_q       <= ox[5:0];
      s1_oy_q       <= oy[5:0];
      s1_last_q     <= (ox + 7'd1 == out_width_q) && (oy + 7'd1 == out_height_q);
      s1_addr_q     <= c;
      // previous pixel writes this column on the same edge
      s1_fwd_q      <= s1_valid_q && s1_pix_q && (s1_addr_q == c);
      s1_fwd_data_q <= lb_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      for (int i = 0; i < KernelTaps; i++) w_q[i] <= '0;
      for (int i = 0; i < ShiftTaps; i++) ws_q[i] <= '0;
    end else if (en) begin
      s1_valid_q <= accept;
      if (s1_valid_q) begin
        if (s1_pix_q) begin
          for (int k = 0; k < 3; k++) begin
            ws_q[2*k]   <= ws_q[2*k+1];
            ws_q[2*k+1] <= cur[k];
          end
        end else begin
          for (int i = 0; i < KernelTaps; i++) begin
            if (s1_widx_q == 4'(i)) w_q[i] <= s1_sample_q;
          end
        end
      end
    end
  end

  // stage 2: product sum, accumulator read
  logic             s2_valid_q, s2_emit_q, s2_first_q, s2_last_q;
  logic [AccAw-1:0] s2_idx_q;
  logic [5:0]       s2_ox_q, s2_oy_q;
  logic [ProdW-1:0] s2_prod_q [KernelTaps];
  logic [SumW-1:0]  sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < KernelTaps; i++) begin
      sum = sum + SumW'($signed(s2_prod_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < KernelTaps; i++) s2_prod_q[i] <= prod[i];
      s2_idx_q   <= s1_idx_q;
      s2_emit_q  <= s1_emit_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_ox_q    <= s1_ox_q;
      s2_oy_q    <= s1_oy_q;
    end
  end

  // stage 3: accumulate with saturation, write back
  logic             s3_valid_q, s3_emit_q, s3_first_q, s3_last_q;
  logic [AccAw-1:0] s3_idx_q;
  logic [5:0]       s3_ox_q, s3_oy_q;
  logic [SumW-1:0]  s3_sum_q;
  logic [AccW-1:0]  acc_mem [MaxOutPixels];
  logic [AccW-1:0]  acc_rdata_q, acc_old, acc_new;
  logic [AccW:0]    total;

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_rdata_q <= acc_mem[s2_idx_q];
      if (s3_valid_q) acc_mem[s3_idx_q] <= acc_new;
      s3_sum_q   <= sum;
      s3_idx_q   <= s2_idx_q;
      s3_emit_q  <= s2_emit_q;
      s3_first_q <= s2_first_q;
      s3_last_q  <= s2_last_q;
      s3_ox_q    <= s2_ox_q;
      s3_oy_q    <= s2_oy_q;
    end
  end

  always_comb begin
    acc_old = s3_first_q ? '0 : acc_rdata_q;
    total   = {acc_old[AccW-1], acc_old} + (AccW+1)'($signed(s3_sum_q));
    if (total[AccW] != total[AccW-1]) begin
      acc_new = total[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_new = total[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q && s1_pix_q && s1_win_q;
      s3_valid_q <= s2_valid_q;
      m_valid_q  <= s3_valid_q && s3_emit_q;
    end
  end

  logic [63:0] m_data_q;
  logic        m_last_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= {4'b0, s3_oy_q, s3_ox_q, acc_new};
      m_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

@@ src/cv3s2_checker.sv @@
module cv3s2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_addr_i,
  input logic [10:0] cfg_wdata_i,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import cv3s2_pkg::*;

  logic [6:0] ow_q, oh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ow_q <= 7'd1;
      oh_q <= 7'd1;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_OUT_WIDTH)  ow_q <= cfg_wdata_i[6:0];
      if (cfg_addr_i == CFG_OUT_HEIGHT) oh_q <= cfg_wdata_i[6:0];
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !cfg_we_i |->
      ({1'b0, m_axis_tdata[53:48]} < ow_q) && ({1'b0, m_axis_tdata[59:54]} < oh_q))
    else $error("result position outside output map");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && !cfg_we_i |->
      ({1'b0, m_axis_tdata[53:48]} + 7'd1 == ow_q) &&
      ({1'b0, m_axis_tdata[59:54]} + 7'd1 == oh_q))
    else $error("tlast away from final output pixel");

endmodule

bind conv3x3_stride2_channel_accumulate cv3s2_checker u_cv3s2_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_addr_i    (cfg_addr_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
